@@ hdl/gct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gct_pkg;
  localparam int MaxRotations = 1024;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NEG      = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  localparam logic [32:0] OneQ30 = 33'h0_4000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_SQRT, S_DIV_C, S_DIV_S, S_WRITE, S_READ, S_READ2, S_DONE
  } state_t;

  // control between the sequencer and the math unit
  typedef struct packed {
    logic sqrt_start;
    logic div_start;
  } math_ctl_t;
endpackage
`default_nettype wire

@@ hdl/givens_coefficient_table.sv @@
`timescale 1ns / 1ps
// Add, from accept to strobe: normalize, square root, two divisions by the norm, one
//   write; the divider sets the pace.
// Read: one registered RAM read. Rejects skip the math and strobe from the done state.
// One request at a time; busy is high until its out_valid strobe.
// Synchronous active-low reset empties the table (count to zero); RAM contents stay.
`default_nettype none
module givens_coefficient_table
  import gct_pkg::*;
#(
  parameter int MAX_ROTATIONS = MaxRotations
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire               in_req_type,
  input  wire signed [15:0] in_row_number,
  input  wire signed [15:0] in_col_number,
  input  wire signed [31:0] in_row_value,
  input  wire signed [31:0] in_col_value,
  input  wire [9:0]         in_read_index,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [9:0]        out_slot,
  output logic [14:0]       out_row_out,
  output logic [14:0]       out_col_out,
  output logic signed [31:0] out_cos_coef,
  output logic signed [31:0] out_sin_coef,
  output logic [10:0]       out_entry_count
);
  localparam int AW = $clog2(MAX_ROTATIONS);
  localparam int CW = AW + 1;
  localparam int EW = 94;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [32:0] a_r, b_r, a_nxt, b_nxt;
  logic na_r, nb_r;
  logic [14:0] row_r, col_r;
  logic [9:0]  idx_r;
  logic [32:0] n_r;
  logic [31:0] c_r, c_nxt, s_r, s_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        ld;
  math_ctl_t   mctl;
  logic        sq_done, dv_done;
  logic [32:0] root, quot;
  logic        we;
  logic [EW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic [32:0] amag, bmag;
  logic [32:0] mx;

  assign amag = in_row_value[31] ? (33'h1_0000_0000 - {1'b0, in_row_value})
                                 : {1'b0, in_row_value};
  assign bmag = in_col_value[31] ? (33'h1_0000_0000 - {1'b0, in_col_value})
                                 : {1'b0, in_col_value};
  assign mx   = (a_r > b_r) ? a_r : b_r;
  assign raddr = AW'(idx_r);

  gct_ram #(.Width(EW), .Depth(MAX_ROTATIONS)) u_ram (
    .clk(clk), .we(we), .waddr(count_r[AW-1:0]),
    .wdata({row_r, col_r, c_r, s_r}), .raddr(raddr), .rdata(rdata));

  gct_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(mctl.sqrt_start),
    .radicand(a_r[31:0] * a_r[31:0] + b_r[31:0] * b_r[31:0]
              + ((a_r[32] | b_r[32]) ? 64'h8000_0000_0000_0000 : 64'd0)),
    .done(sq_done), .root(root));

  gct_div u_div (
    .clk(clk), .rst_n(rst_n), .start(mctl.div_start),
    .mag(state_r == S_SQRT ? b_r : a_r), .den(state_r == S_SQRT ? root : n_r),
    .done(dv_done), .quot(quot));

  function automatic logic [31:0] apply_sign(input logic [32:0] q, input logic neg);
    logic [32:0] t;
    t = 33'h1_0000_0000 - q;
    return neg ? t[31:0] : q[31:0];
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (ld) begin
        if (st_nxt != ST_OK)  state_nxt = S_DONE;
        else if (in_req_type) state_nxt = S_READ;
        else                  state_nxt = S_NORM;
      end
      S_NORM:  if (mx[32:30] != 3'd0) state_nxt = S_SQRT;
      S_SQRT:  if (sq_done) state_nxt = S_DIV_C;
      S_DIV_C: if (dv_done) state_nxt = S_DIV_S;
      S_DIV_S: if (dv_done) state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_IDLE;
      S_READ:  state_nxt = S_READ2;
      S_READ2: state_nxt = S_IDLE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    ld        = start && state_r == S_IDLE;
    busy      = state_r != S_IDLE;
    mctl.sqrt_start = state_r == S_NORM && mx[32:30] != 3'd0;
    mctl.div_start  = (state_r == S_SQRT && sq_done) || (state_r == S_DIV_C && dv_done);
    we        = state_r == S_WRITE;
    count_nxt = count_r + (we ? CW'(1) : CW'(0));
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    s_nxt = s_r;
    st_nxt = ST_OK;
    if (in_req_type) begin
      if (32'(in_read_index) >= 32'(count_r) || 32'(in_read_index) >= MAX_ROTATIONS)
        st_nxt = ST_RANGE;
    end else if (in_row_number[15] || in_col_number[15]) st_nxt = ST_NEG;
    else if (in_row_value == '0 && in_col_value == '0)  st_nxt = ST_ZERO;
    else if (32'(count_r) >= MAX_ROTATIONS)             st_nxt = ST_FULL;
    if (ld) begin
      a_nxt = amag;
      b_nxt = bmag;
    end else if (state_r == S_NORM && mx[32:30] == 3'd0) begin
      a_nxt = a_r << 1;
      b_nxt = b_r << 1;
    end
    if (state_r == S_DIV_C && dv_done) c_nxt = apply_sign(quot, nb_r);
    if (state_r == S_DIV_S && dv_done) s_nxt = apply_sign(quot, na_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_valid <= state_r == S_WRITE || state_r == S_READ2 || state_r == S_DONE;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    s_r <= s_nxt;
    if (state_r == S_SQRT && sq_done) n_r <= root;
    if (ld) begin
      na_r  <= in_row_value[31];
      nb_r  <= in_col_value[31];
      row_r <= in_row_number[14:0];
      col_r <= in_col_number[14:0];
      idx_r <= in_read_index;
      st_r  <= st_nxt;
    end
    case (state_r)
      S_WRITE: begin
        out_status   <= ST_OK;
        out_slot     <= 10'(count_r);
        out_row_out  <= row_r;
        out_col_out  <= col_r;
        out_cos_coef <= c_r;
        out_sin_coef <= s_r;
      end
      S_READ2: begin
        out_status   <= ST_OK;
        out_slot     <= idx_r;
        {out_row_out, out_col_out, out_cos_coef, out_sin_coef} <= rdata;
      end
      S_DONE: begin
        out_status   <= st_r;
        out_slot     <= (st_r == ST_RANGE) ? idx_r : 10'd0;
        out_row_out  <= '0;
        out_col_out  <= '0;
        out_cos_coef <= '0;
        out_sin_coef <= '0;
      end
      default: ;
    endcase
    out_entry_count <= 11'(count_nxt);
  end
endmodule
`default_nettype wire

@@ hdl/gct_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gct_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(Depth)-1:0] waddr,
  input  wire [Width-1:0]         wdata,
  input  wire [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]        rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/gct_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Integer square root of a 64-bit value, one result bit per cycle.
module gct_sqrt (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire [63:0]  radicand,
  output logic        done,
  output logic [32:0] root
);
  logic [63:0] rem_r, rem_nxt;
  logic [32:0] res_r, res_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [65:0] trial;
  logic [63:0] rem_step;
  logic [32:0] res_step;

  // final bit is decided in the done cycle, so the root comes from the step value
  assign root = res_step;

  always_comb begin
    // trial = 4*res + 1 shifted into place by remaining bit position
    trial    = ({33'd0, res_r} << (cnt_r + 6'd1)) + (66'd1 << {cnt_r, 1'b0});
    rem_step = rem_r;
    res_step = res_r;
    if ({2'b00, rem_r} >= trial) begin
      rem_step = rem_r - trial[63:0];
      res_step = res_r | (33'd1 << cnt_r);
    end
    done     = busy_r && cnt_r == 6'd0;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      rem_nxt = rem_step;
      res_nxt = res_step;
      if (cnt_r == 6'd0) busy_nxt = 1'b0;
      else               cnt_nxt  = cnt_r - 6'd1;
    end
    if (start) begin
      rem_nxt  = radicand;
      res_nxt  = '0;
      cnt_nxt  = 6'd31;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= busy_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    cnt_r <= cnt_nxt;
  end
endmodule
`default_nettype wire

@@ hdl/gct_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider: floor((mag<<30 + n/2)/n), saturated to 1.0.
module gct_div
  import gct_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire [32:0]  mag,
  input  wire [32:0]  den,
  output logic        done,
  output logic [32:0] quot
);
  logic [63:0] num_r, num_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [33:0] q_r, q_nxt;
  logic [32:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [34:0] shifted;
  logic [33:0] rem_step;
  logic [33:0] q_step;

  // last quotient bit lands in the done cycle; a new start may follow at once
  assign quot = (q_step > {1'b0, OneQ30}) ? OneQ30 : q_step[32:0];

  always_comb begin
    shifted = {rem_r, num_r[63]};
    if (shifted >= {2'b00, den_r}) begin
      rem_step = shifted[33:0] - {1'b0, den_r};
      q_step   = {q_r[32:0], 1'b1};
    end else begin
      rem_step = shifted[33:0];
      q_step   = {q_r[32:0], 1'b0};
    end
    done     = busy_r && cnt_r == 7'd0;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      num_nxt = {num_r[62:0], 1'b0};
      rem_nxt = rem_step;
      q_nxt   = q_step;
      if (cnt_r == 7'd0) busy_nxt = 1'b0;
      else               cnt_nxt  = cnt_r - 7'd1;
    end
    if (start) begin
      num_nxt  = {1'b0, mag, 30'd0} + {31'd0, den[32:1]};
      rem_nxt  = '0;
      q_nxt    = '0;
      den_nxt  = den;
      cnt_nxt  = 7'd63;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= busy_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end
endmodule
`default_nettype wire

@@ hdl/gct_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gct_checker
  import gct_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        out_valid,
  input wire [2:0]  out_status,
  input wire [10:0] out_entry_count
);
  // a strobe always ends a busy spell
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("strobe while busy");
  // no back-to-back strobes
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double strobe");
  // status code stays within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_RANGE) else $error("bad status %0d", out_status);
  // accepted request makes block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("not busy after accept");
endmodule

bind givens_coefficient_table gct_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_status(out_status), .out_entry_count(out_entry_count));
`default_nettype wire
